// ===== hdl/oig_pkg.sv =====
package oig_pkg;

    // field widths of the request, result and configuration port
    localparam int COORD_W    = 8;
    localparam int VALUE_W    = 8;
    localparam int HALF_W     = 8;
    localparam int GRID_W     = 9;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = GRID_W;
    localparam int STEP_W     = 3;

    typedef logic [CFG_IDX_W-1:0] cfg_index_t;

    // configuration register indexes
    localparam cfg_index_t REG_INFLATION = cfg_index_t'(0);
    localparam cfg_index_t REG_GRID      = cfg_index_t'(1);
    localparam cfg_index_t REG_START_ROW = cfg_index_t'(2);
    localparam cfg_index_t REG_START_COL = cfg_index_t'(3);

    // configuration reset values
    localparam logic [HALF_W-1:0]  INFLATION_RESET = 8'd2;
    localparam logic [GRID_W-1:0]  GRID_RESET      = 9'd256;
    localparam logic [COORD_W-1:0] START_RESET     = 8'd0;

    // request kinds
    localparam logic KIND_WRITE = 1'b0;
    localparam logic KIND_READ  = 1'b1;

    // cell values
    localparam logic [VALUE_W-1:0] OBSTACLE_VALUE = 8'd100;
    localparam logic [VALUE_W-1:0] INFLATED_VALUE = 8'd30;

    // last step of the bit-serial start reduction
    localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(COORD_W - 1);

    typedef enum logic {
        ALU_ADD,
        ALU_SUB
    } alu_op_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_WRITE,
        ST_OWN_RD,
        ST_OWN_CHK,
        ST_DIV_R,
        ST_DIV_C,
        ST_UR,
        ST_UR_FIX,
        ST_UC,
        ST_UC_FIX,
        ST_R0,
        ST_R1_SPAN,
        ST_R1_CMP,
        ST_R1_ADD,
        ST_C0,
        ST_C1_SPAN,
        ST_C1_CMP,
        ST_C1_ADD,
        ST_SA_ADD,
        ST_SA_WRAP,
        ST_SB_ADD,
        ST_SB_WRAP,
        ST_SCAN,
        ST_DRAIN,
        ST_DONE
    } oig_state_t;

endpackage

// ===== hdl/oig_if.sv =====
// request channel: one cell write or one inflated read
interface oig_item_if import oig_pkg::*; ();
    logic               valid;
    logic               ready;
    logic               kind;
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
    logic [VALUE_W-1:0] cell_value;

    modport source (output valid, output kind, output row, output col, output cell_value,
                    input ready);
    modport sink (input valid, input kind, input row, input col, input cell_value,
                  output ready);
endinterface

// result channel: inflated value of a read
interface oig_result_if import oig_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [VALUE_W-1:0] inflated_value;

    modport source (output valid, output inflated_value, input ready);
    modport sink (input valid, input inflated_value, output ready);
endinterface

// ===== hdl/obstacle_inflation_grid.sv =====
// Inflated occupancy grid held as a circular buffer.
// Requests arrive on the item channel (valid/ready); kind selects a cell
// write or an inflated read. Each read gives one result on the result
// channel; writes give none. Configuration is a plain write port
// (wr_en, wr_index, wr_data); the user must see that it is changed only
// while the block is idle, as the block itself does not enforce this.
// Only one request is in work at a time; item.ready is high in idle only.
// A write updates the store in ST_WRITE, the cycle after acceptance, then idles.
// A read of a cell outside the map goes from ST_OWN_RD straight to the result,
// a read of an obstacle cell by way of ST_OWN_CHK. Any other read runs a
// set-up (an 8-step start reduction per axis plus window bounds, all on the
// one shared add/subtract unit), then scans up to (2N+1)^2 window cells, 25 at
// the default half-width of 2, one cell per cycle; the scan stops early at the
// first obstacle. ST_DRAIN drains the registered store read and ST_DONE
// presents the result.
// The result is held until result.ready; a stalled receiver holds the block.
// Reset restores the configuration defaults and returns to idle; the cell
// store is not cleared and must be written before it is read.
module obstacle_inflation_grid import oig_pkg::*; #(
    parameter int GRID_SIDE = 256
) (
    input  logic                  clk,
    input  logic                  rst_n,
    oig_item_if.sink              item,
    oig_result_if.source          result,
    input  logic                  wr_en,
    input  logic [CFG_IDX_W-1:0]  wr_index,
    input  logic [CFG_DATA_W-1:0] wr_data
);

    localparam int IW    = $clog2(GRID_SIDE);
    localparam int VW    = (IW + 2 > 10) ? IW + 2 : 10;
    localparam int DEPTH = GRID_SIDE * GRID_SIDE;
    localparam int AW    = $clog2(DEPTH);
    localparam logic [VW-1:0] SIDE_V = VW'(GRID_SIDE);

    // configuration
    logic [HALF_W-1:0]  inflation_reg;
    logic [GRID_W-1:0]  grid_reg;
    logic [COORD_W-1:0] start_row_reg;
    logic [COORD_W-1:0] start_col_reg;

    // control
    oig_state_t        state_reg, state_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              pend_reg, pend_next;

    // request and working values
    logic [COORD_W-1:0] row_reg, row_next;
    logic [COORD_W-1:0] col_reg, col_next;
    logic [VALUE_W-1:0] value_reg, value_next;
    logic [VALUE_W-1:0] own_reg, own_next;
    logic [VALUE_W-1:0] res_reg, res_next;
    logic [VW-1:0]      tmp_reg, tmp_next;
    logic [VW-1:0]      sr_reg, sr_next;
    logic [VW-1:0]      sc_reg, sc_next;
    logic [VW-1:0]      ur_reg, ur_next;
    logic [VW-1:0]      uc_reg, uc_next;
    logic [VW-1:0]      r0_reg, r0_next;
    logic [VW-1:0]      r1_reg, r1_next;
    logic [VW-1:0]      c0_reg, c0_next;
    logic [VW-1:0]      c1_reg, c1_next;
    logic [VW-1:0]      a_reg, a_next;
    logic [VW-1:0]      b_reg, b_next;
    logic [VW-1:0]      sa_reg, sa_next;
    logic [VW-1:0]      sb_reg, sb_next;
    logic [VW-1:0]      sb0_reg, sb0_next;

    // derived values
    logic [VW-1:0] n_w;
    logic [VW-1:0] nm1_w;
    logic [VW-1:0] half_w;
    logic [VW-1:0] row_w;
    logic [VW-1:0] col_w;
    logic          in_range;
    logic          div_bit;
    logic [VW-1:0] rem_sh;
    logic [VW-1:0] rem_new;

    // shared unit and store
    alu_op_t            alu_op;
    logic [VW-1:0]      alu_a;
    logic [VW-1:0]      alu_b;
    logic [VW-1:0]      alu_sum;
    logic               alu_neg;
    logic               ram_we;
    logic [AW-1:0]      ram_waddr;
    logic [AW-1:0]      ram_raddr;
    logic [VALUE_W-1:0] ram_rdata;

    function automatic logic [AW-1:0] cell_addr(input logic [VW-1:0] r,
                                                input logic [VW-1:0] c);
        return AW'(r) * AW'(GRID_SIDE) + AW'(c);
    endfunction

    oig_alu #(
        .VW (VW)
    ) u_alu (
        .op  (alu_op),
        .a   (alu_a),
        .b   (alu_b),
        .sum (alu_sum),
        .neg (alu_neg)
    );

    oig_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (value_reg),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inflation_reg <= INFLATION_RESET;
            grid_reg      <= GRID_RESET;
            start_row_reg <= START_RESET;
            start_col_reg <= START_RESET;
        end
        else if (wr_en)
        begin
            case (wr_index)
                REG_INFLATION: inflation_reg <= wr_data[HALF_W-1:0];
                REG_GRID:      grid_reg      <= wr_data;
                REG_START_ROW: start_row_reg <= wr_data[COORD_W-1:0];
                REG_START_COL: start_col_reg <= wr_data[COORD_W-1:0];
                default:       ;
            endcase
        end
    end

    // map side clamped to 1 .. GRID_SIDE
    always_comb
    begin
        if (grid_reg == '0)
        begin
            n_w = VW'(1);
        end
        else if (VW'(grid_reg) > SIDE_V)
        begin
            n_w = SIDE_V;
        end
        else
        begin
            n_w = VW'(grid_reg);
        end
    end

    assign nm1_w    = n_w - VW'(1);
    assign half_w   = VW'(inflation_reg);
    assign row_w    = VW'(row_reg);
    assign col_w    = VW'(col_reg);
    assign in_range = (row_w < n_w) && (col_w < n_w);
    assign ram_waddr = cell_addr(row_w, col_w);

    // one bit a step of start modulo map side, msb first
    assign div_bit = (state_reg == ST_DIV_R) ? start_row_reg[STEP_LAST - step_reg]
                                             : start_col_reg[STEP_LAST - step_reg];
    assign rem_sh  = {tmp_reg[VW-2:0], div_bit};
    assign rem_new = alu_neg ? rem_sh : alu_sum;

    // handshake outputs
    assign item.ready            = (state_reg == ST_IDLE);
    assign result.valid          = (state_reg == ST_DONE);
    assign result.inflated_value = res_reg;

    // sequencer: next state, shared unit operands and working values
    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        pend_next  = pend_reg;
        row_next   = row_reg;
        col_next   = col_reg;
        value_next = value_reg;
        own_next   = own_reg;
        res_next   = res_reg;
        tmp_next   = tmp_reg;
        sr_next    = sr_reg;
        sc_next    = sc_reg;
        ur_next    = ur_reg;
        uc_next    = uc_reg;
        r0_next    = r0_reg;
        r1_next    = r1_reg;
        c0_next    = c0_reg;
        c1_next    = c1_reg;
        a_next     = a_reg;
        b_next     = b_reg;
        sa_next    = sa_reg;
        sb_next    = sb_reg;
        sb0_next   = sb0_reg;
        alu_op     = ALU_ADD;
        alu_a      = '0;
        alu_b      = '0;
        ram_we     = 1'b0;
        ram_raddr  = cell_addr(sa_reg, sb_reg);

        case (state_reg)
            ST_IDLE:
            begin
                if (item.valid)
                begin
                    row_next   = item.row;
                    col_next   = item.col;
                    value_next = item.cell_value;
                    state_next = (item.kind == KIND_READ) ? ST_OWN_RD : ST_WRITE;
                end
            end

            ST_WRITE:
            begin
                ram_we     = in_range;
                state_next = ST_IDLE;
            end

            // own cell first
            ST_OWN_RD:
            begin
                ram_raddr = cell_addr(row_w, col_w);
                if (!in_range)
                begin
                    res_next   = '0;
                    state_next = ST_DONE;
                end
                else
                begin
                    state_next = ST_OWN_CHK;
                end
            end

            ST_OWN_CHK:
            begin
                if (ram_rdata == OBSTACLE_VALUE)
                begin
                    res_next   = OBSTACLE_VALUE;
                    state_next = ST_DONE;
                end
                else
                begin
                    own_next   = ram_rdata;
                    tmp_next   = '0;
                    step_next  = '0;
                    state_next = ST_DIV_R;
                end
            end

            // start row and column reduced modulo the map side
            ST_DIV_R:
            begin
                alu_op    = ALU_SUB;
                alu_a     = rem_sh;
                alu_b     = n_w;
                step_next = step_reg + STEP_W'(1);
                if (step_reg == STEP_LAST)
                begin
                    sr_next    = rem_new;
                    tmp_next   = '0;
                    state_next = ST_DIV_C;
                end
                else
                begin
                    tmp_next = rem_new;
                end
            end

            ST_DIV_C:
            begin
                alu_op    = ALU_SUB;
                alu_a     = rem_sh;
                alu_b     = n_w;
                step_next = step_reg + STEP_W'(1);
                if (step_reg == STEP_LAST)
                begin
                    sc_next    = rem_new;
                    tmp_next   = '0;
                    state_next = ST_UR;
                end
                else
                begin
                    tmp_next = rem_new;
                end
            end

            // unwrapped row and column of the cell
            ST_UR:
            begin
                alu_op     = ALU_SUB;
                alu_a      = row_w;
                alu_b      = sr_reg;
                ur_next    = alu_sum;
                state_next = alu_neg ? ST_UR_FIX : ST_UC;
            end

            ST_UR_FIX:
            begin
                alu_a      = ur_reg;
                alu_b      = n_w;
                ur_next    = alu_sum;
                state_next = ST_UC;
            end

            ST_UC:
            begin
                alu_op     = ALU_SUB;
                alu_a      = col_w;
                alu_b      = sc_reg;
                uc_next    = alu_sum;
                state_next = alu_neg ? ST_UC_FIX : ST_R0;
            end

            ST_UC_FIX:
            begin
                alu_a      = uc_reg;
                alu_b      = n_w;
                uc_next    = alu_sum;
                state_next = ST_R0;
            end

            // row window clipped at the map edges
            ST_R0:
            begin
                alu_op     = ALU_SUB;
                alu_a      = ur_reg;
                alu_b      = half_w;
                r0_next    = alu_neg ? '0 : alu_sum;
                state_next = ST_R1_SPAN;
            end

            ST_R1_SPAN:
            begin
                alu_op     = ALU_SUB;
                alu_a      = nm1_w;
                alu_b      = ur_reg;
                tmp_next   = alu_sum;
                state_next = ST_R1_CMP;
            end

            ST_R1_CMP:
            begin
                alu_op = ALU_SUB;
                alu_a  = half_w;
                alu_b  = tmp_reg;
                if (alu_neg)
                begin
                    state_next = ST_R1_ADD;
                end
                else
                begin
                    r1_next    = nm1_w;
                    state_next = ST_C0;
                end
            end

            ST_R1_ADD:
            begin
                alu_a      = ur_reg;
                alu_b      = half_w;
                r1_next    = alu_sum;
                state_next = ST_C0;
            end

            // column window clipped at the map edges
            ST_C0:
            begin
                alu_op     = ALU_SUB;
                alu_a      = uc_reg;
                alu_b      = half_w;
                c0_next    = alu_neg ? '0 : alu_sum;
                state_next = ST_C1_SPAN;
            end

            ST_C1_SPAN:
            begin
                alu_op     = ALU_SUB;
                alu_a      = nm1_w;
                alu_b      = uc_reg;
                tmp_next   = alu_sum;
                state_next = ST_C1_CMP;
            end

            ST_C1_CMP:
            begin
                alu_op = ALU_SUB;
                alu_a  = half_w;
                alu_b  = tmp_reg;
                if (alu_neg)
                begin
                    state_next = ST_C1_ADD;
                end
                else
                begin
                    c1_next    = nm1_w;
                    state_next = ST_SA_ADD;
                end
            end

            ST_C1_ADD:
            begin
                alu_a      = uc_reg;
                alu_b      = half_w;
                c1_next    = alu_sum;
                state_next = ST_SA_ADD;
            end

            // storage position of the window corner
            ST_SA_ADD:
            begin
                alu_a      = r0_reg;
                alu_b      = sr_reg;
                tmp_next   = alu_sum;
                state_next = ST_SA_WRAP;
            end

            ST_SA_WRAP:
            begin
                alu_op     = ALU_SUB;
                alu_a      = tmp_reg;
                alu_b      = n_w;
                sa_next    = alu_neg ? tmp_reg : alu_sum;
                a_next     = r0_reg;
                state_next = ST_SB_ADD;
            end

            ST_SB_ADD:
            begin
                alu_a      = c0_reg;
                alu_b      = sc_reg;
                tmp_next   = alu_sum;
                state_next = ST_SB_WRAP;
            end

            ST_SB_WRAP:
            begin
                alu_op     = ALU_SUB;
                alu_a      = tmp_reg;
                alu_b      = n_w;
                sb_next    = alu_neg ? tmp_reg : alu_sum;
                sb0_next   = alu_neg ? tmp_reg : alu_sum;
                b_next     = c0_reg;
                pend_next  = 1'b0;
                state_next = ST_SCAN;
            end

            // one store read issued a cycle, checked the cycle after
            ST_SCAN:
            begin
                if (pend_reg && (ram_rdata == OBSTACLE_VALUE))
                begin
                    res_next   = INFLATED_VALUE;
                    pend_next  = 1'b0;
                    state_next = ST_DONE;
                end
                else
                begin
                    pend_next = 1'b1;
                    if ((a_reg == r1_reg) && (b_reg == c1_reg))
                    begin
                        state_next = ST_DRAIN;
                    end
                    else if (b_reg == c1_reg)
                    begin
                        b_next  = c0_reg;
                        sb_next = sb0_reg;
                        a_next  = a_reg + VW'(1);
                        sa_next = (sa_reg == nm1_w) ? '0 : sa_reg + VW'(1);
                    end
                    else
                    begin
                        b_next  = b_reg + VW'(1);
                        sb_next = (sb_reg == nm1_w) ? '0 : sb_reg + VW'(1);
                    end
                end
            end

            // last window cell
            ST_DRAIN:
            begin
                res_next   = (ram_rdata == OBSTACLE_VALUE) ? INFLATED_VALUE : own_reg;
                pend_next  = 1'b0;
                state_next = ST_DONE;
            end

            ST_DONE:
            begin
                if (result.ready)
                begin
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
            pend_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            pend_reg  <= pend_next;
        end
    end

    // working values
    always_ff @(posedge clk)
    begin
        row_reg   <= row_next;
        col_reg   <= col_next;
        value_reg <= value_next;
        own_reg   <= own_next;
        res_reg   <= res_next;
        tmp_reg   <= tmp_next;
        sr_reg    <= sr_next;
        sc_reg    <= sc_next;
        ur_reg    <= ur_next;
        uc_reg    <= uc_next;
        r0_reg    <= r0_next;
        r1_reg    <= r1_next;
        c0_reg    <= c0_next;
        c1_reg    <= c1_next;
        a_reg     <= a_next;
        b_reg     <= b_next;
        sa_reg    <= sa_next;
        sb_reg    <= sb_next;
        sb0_reg   <= sb0_next;
    end

endmodule

// ===== hdl/oig_ram.sv =====
module oig_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== hdl/oig_alu.sv =====
module oig_alu import oig_pkg::*; #(
    parameter int VW = 10
) (
    input  alu_op_t       op,
    input  logic [VW-1:0] a,
    input  logic [VW-1:0] b,
    output logic [VW-1:0] sum,
    output logic          neg
);

    logic [VW:0] full;

    // shared add / subtract, borrow out flags a negative difference
    always_comb
    begin
        case (op)
            ALU_ADD: full = {1'b0, a} + {1'b0, b};
            ALU_SUB: full = {1'b0, a} - {1'b0, b};
            default: full = {1'b0, a};
        endcase
    end

    assign sum = full[VW-1:0];
    assign neg = (op == ALU_SUB) && full[VW];

endmodule

// ===== dv/tb_obstacle_inflation_grid.sv =====
module tb_obstacle_inflation_grid;
    import oig_pkg::*;

    localparam int GRID_SIDE        = 256;
    localparam int SMALL_MAP_LIMIT  = 32;
    localparam int PATCH_BASE       = 250;
    localparam int PATCH_SPAN       = 12;
    localparam int SETTLE_CYCLES    = 16;
    localparam int LONG_HOLD_CYCLES = 300;
    localparam int WATCHDOG_LIMIT   = 5000;
    localparam int REPORT_LIMIT     = 64;
    localparam int PHASE_ITEMS      = 70;

    localparam cfg_index_t REG_UNUSED = cfg_index_t'(7);

    typedef enum int {
        SINK_OPEN,
        SINK_COIN,
        SINK_SPARSE,
        SINK_SHUT
    } sink_mode_t;

    typedef struct {
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] col;
        logic [VALUE_W-1:0] value;
    } read_result_t;

    logic clk;
    logic rst_n;
    logic                  wr_en;
    logic [CFG_IDX_W-1:0]  wr_index;
    logic [CFG_DATA_W-1:0] wr_data;

    oig_item_if   item();
    oig_result_if result();

    obstacle_inflation_grid #(
        .GRID_SIDE(GRID_SIDE)
    ) u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .item     (item),
        .result   (result),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data)
    );

    // own copy of the map and its registers
    logic [VALUE_W-1:0]  cell_mem     [GRID_SIDE][GRID_SIDE];
    bit                  cell_written [GRID_SIDE][GRID_SIDE];
    logic [HALF_W-1:0]   half_width = INFLATION_RESET;
    logic [GRID_W-1:0]   map_cells  = GRID_RESET;
    logic [COORD_W-1:0]  origin_row = START_RESET;
    logic [COORD_W-1:0]  origin_col = START_RESET;

    read_result_t pending_reads [$];
    int           mismatch_count;
    int           burst_left;
    int           idle_cycles;
    bit           hold_results;

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int side_cells();
        int side;
        side = int'(map_cells);
        if (side == 0)
            side = 1;
        if (side > GRID_SIDE)
            side = GRID_SIDE;
        return side;
    endfunction

    // inflated value of one cell; covered tells whether every cell touched was written
    function automatic logic [VALUE_W-1:0] inflate_cell(input logic [COORD_W-1:0] row,
                                                        input logic [COORD_W-1:0] col,
                                                        output bit covered);
        int side, half, sr, sc, ur, uc, r0, r1, c0, c1, sa, sb;
        logic [VALUE_W-1:0] own;
        bit hit;
        covered = 1'b1;
        side = side_cells();
        if (row >= side || col >= side)
            return '0;
        covered = cell_written[row][col];
        own = cell_mem[row][col];
        if (own == OBSTACLE_VALUE)
            return OBSTACLE_VALUE;
        half = int'(half_width);
        sr = int'(origin_row) % side;
        sc = int'(origin_col) % side;
        ur = (int'(row) + side - sr) % side;
        uc = (int'(col) + side - sc) % side;
        r0 = (ur > half) ? ur - half : 0;
        r1 = (side - 1 - ur > half) ? ur + half : side - 1;
        c0 = (uc > half) ? uc - half : 0;
        c1 = (side - 1 - uc > half) ? uc + half : side - 1;
        hit = 1'b0;
        // window in unwrapped coordinates, mapped back to storage
        for (int a = r0; a <= r1; a++)
        begin
            sa = (a + sr) % side;
            for (int b = c0; b <= c1; b++)
            begin
                sb = (b + sc) % side;
                if (!cell_written[sa][sb])
                    covered = 1'b0;
                if (cell_mem[sa][sb] == OBSTACLE_VALUE)
                    hit = 1'b1;
            end
        end
        return hit ? INFLATED_VALUE : own;
    endfunction

    function automatic logic [VALUE_W-1:0] random_cell_value(input int obstacle_odds);
        if ($urandom_range(0, obstacle_odds - 1) == 0)
            return OBSTACLE_VALUE;
        if ($urandom_range(0, 15) == 0)
            return INFLATED_VALUE;
        return VALUE_W'($urandom_range(0, 255));
    endfunction

    // coordinate inside the area kept fully written for the current map
    function automatic logic [COORD_W-1:0] area_coord();
        int side;
        side = side_cells();
        if (side <= SMALL_MAP_LIMIT)
            return COORD_W'($urandom_range(0, side - 1));
        return COORD_W'((PATCH_BASE + $urandom_range(0, PATCH_SPAN - 1)) % GRID_SIDE);
    endfunction

    task automatic pick_outside(output logic [COORD_W-1:0] row, output logic [COORD_W-1:0] col);
        int side;
        side = side_cells();
        if ($urandom_range(0, 1) == 1)
        begin
            row = COORD_W'($urandom_range(side, GRID_SIDE - 1));
            col = COORD_W'($urandom_range(0, 255));
        end
        else
        begin
            row = COORD_W'($urandom_range(0, 255));
            col = COORD_W'($urandom_range(side, GRID_SIDE - 1));
        end
    endtask

    task automatic report_mismatch(input string what, input logic [COORD_W-1:0] row,
                                   input logic [COORD_W-1:0] col, input logic [VALUE_W-1:0] got,
                                   input logic [VALUE_W-1:0] want);
        if (mismatch_count < REPORT_LIMIT)
            $display("mismatch at %0t: %s row %0d col %0d got %0d want %0d",
                     $time, what, row, col, got, want);
        mismatch_count++;
    endtask

    // send one request, wait for it to be taken, then update the map copy
    task automatic issue_request(input logic kind, input logic [COORD_W-1:0] row,
                                 input logic [COORD_W-1:0] col,
                                 input logic [VALUE_W-1:0] value);
        int gap;
        bit covered;
        read_result_t entry;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 16);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                item.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        item.valid      <= 1'b1;
        item.kind       <= kind;
        item.row        <= row;
        item.col        <= col;
        item.cell_value <= value;
        do
        begin
            @(posedge clk);
        end
        while (!item.ready);
        if (kind == KIND_READ)
        begin
            entry.row   = row;
            entry.col   = col;
            entry.value = inflate_cell(row, col, covered);
            pending_reads.push_back(entry);
        end
        else if (row < side_cells() && col < side_cells())
        begin
            cell_mem[row][col]     = value;
            cell_written[row][col] = 1'b1;
        end
    endtask

    // sender stops and waits until every read has answered
    task automatic wait_idle();
        item.valid <= 1'b0;
        while (pending_reads.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_register(input cfg_index_t index, input logic [CFG_DATA_W-1:0] data);
        @(posedge clk);
        wr_en    <= 1'b1;
        wr_index <= index;
        wr_data  <= data;
        @(posedge clk);
        wr_en <= 1'b0;
        case (index)
            REG_INFLATION: half_width = data[HALF_W-1:0];
            REG_GRID:      map_cells  = data[GRID_W-1:0];
            REG_START_ROW: origin_row = data[COORD_W-1:0];
            REG_START_COL: origin_col = data[COORD_W-1:0];
            default:       ;
        endcase
    endtask

    task automatic set_map(input int half, input int side, input int srow, input int scol);
        wait_idle();
        write_register(REG_INFLATION, CFG_DATA_W'(half));
        write_register(REG_GRID, CFG_DATA_W'(side));
        write_register(REG_START_ROW, CFG_DATA_W'(srow));
        write_register(REG_START_COL, CFG_DATA_W'(scol));
    endtask

    // one random request, mostly reads and writes inside the written area
    task automatic random_request();
        int side, pick, tries;
        bit covered;
        logic [COORD_W-1:0] row, col;
        side = side_cells();
        pick = $urandom_range(0, 99);
        if (side < GRID_SIDE && pick >= 95)
        begin
            pick_outside(row, col);
            issue_request(KIND_WRITE, row, col, random_cell_value(4));
        end
        else if (side < GRID_SIDE && pick >= 88)
        begin
            pick_outside(row, col);
            issue_request(KIND_READ, row, col, VALUE_W'($urandom_range(0, 255)));
        end
        else if (pick >= 55)
        begin
            issue_request(KIND_WRITE, area_coord(), area_coord(), random_cell_value(12));
        end
        else
        begin
            tries = 0;
            do
            begin
                row = area_coord();
                col = area_coord();
                void'(inflate_cell(row, col, covered));
                tries++;
            end
            while (!covered && tries < 40);
            if (covered)
                issue_request(KIND_READ, row, col, VALUE_W'($urandom_range(0, 255)));
            else
                issue_request(KIND_WRITE, row, col, random_cell_value(12));
        end
    endtask

    // configure, make sure the working area is written, then random traffic
    task automatic run_phase(input int half, input int side, input int srow, input int scol,
                             input int count);
        int base, span, r, c;
        set_map(half, side, srow, scol);
        if (side_cells() <= SMALL_MAP_LIMIT)
        begin
            base = 0;
            span = side_cells();
        end
        else
        begin
            base = PATCH_BASE;
            span = PATCH_SPAN;
        end
        for (int i = 0; i < span; i++)
        begin
            for (int j = 0; j < span; j++)
            begin
                r = (base + i) % GRID_SIDE;
                c = (base + j) % GRID_SIDE;
                if (!cell_written[r][c])
                    issue_request(KIND_WRITE, COORD_W'(r), COORD_W'(c), random_cell_value(20));
            end
        end
        repeat (count) random_request();
    endtask

    // one-cell map, off-map requests, unknown register, edge clipping on a tiny map
    task automatic test_directed();
        logic [VALUE_W-1:0] tiny_map [9];
        tiny_map = '{OBSTACLE_VALUE, 8'd0, INFLATED_VALUE, 8'd255, 8'd128, 8'd1, 8'd127,
                     8'd99, 8'd101};
        set_map(0, 0, 0, 0);
        write_register(REG_UNUSED, '1);
        issue_request(KIND_WRITE, 8'd0, 8'd0, 8'hFF);
        issue_request(KIND_READ, 8'd0, 8'd0, 8'h00);
        issue_request(KIND_READ, 8'd1, 8'd0, 8'hFF);
        issue_request(KIND_READ, 8'd0, 8'hFF, 8'h5A);
        issue_request(KIND_WRITE, 8'hFF, 8'hFF, OBSTACLE_VALUE);
        issue_request(KIND_READ, 8'd0, 8'd0, 8'hFF);
        // start row beyond the map size, obstacle sits across the unwrapped edge
        set_map(1, 3, 4, 2);
        for (int r = 0; r < 3; r++)
            for (int c = 0; c < 3; c++)
                issue_request(KIND_WRITE, COORD_W'(r), COORD_W'(c), tiny_map[r * 3 + c]);
        for (int r = 0; r < 3; r++)
            for (int c = 0; c < 3; c++)
                issue_request(KIND_READ, COORD_W'(r), COORD_W'(c), 8'h00);
    endtask

    // extremes of every register, then random map settings
    task automatic test_map_sweep();
        int fixed_half [8] = '{2, 1, 255, 0, 0, 3, 255, 4};
        int fixed_side [8] = '{256, 511, 16, 1, 0, 257, 5, 12};
        int fixed_srow [8] = '{0, 250, 255, 0, 7, 252, 3, 200};
        int fixed_scol [8] = '{0, 252, 255, 0, 200, 0, 131, 9};
        int half;
        for (int p = 0; p < 8; p++)
            run_phase(fixed_half[p], fixed_side[p], fixed_srow[p], fixed_scol[p], PHASE_ITEMS);
        for (int p = 0; p < 6; p++)
        begin
            half = ($urandom_range(0, 5) == 0) ? 255 : $urandom_range(0, 4);
            run_phase(half, $urandom_range(2, 16), $urandom_range(0, 255),
                      $urandom_range(0, 255), PHASE_ITEMS);
        end
    endtask

    // receiver shut for a long stretch while requests keep coming, then a drain
    task automatic test_backpressure();
        run_phase(2, 8, 3, 5, 10);
        hold_results = 1'b1;
        repeat (12) random_request();
        wait_idle();
        repeat (30) random_request();
    endtask

    // result receiver with its own stall pattern
    initial
    begin : result_sink
        int run_left;
        sink_mode_t mode;
        run_left = 0;
        mode = SINK_OPEN;
        result.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_results)
            begin
                result.ready <= 1'b0;
                repeat (LONG_HOLD_CYCLES) @(posedge clk);
                hold_results = 1'b0;
            end
            else
            begin
                if (run_left == 0)
                begin
                    mode = sink_mode_t'($urandom_range(0, 3));
                    run_left = (mode == SINK_SHUT) ? $urandom_range(1, 12) : $urandom_range(1, 40);
                end
                run_left--;
                case (mode)
                    SINK_OPEN:   result.ready <= 1'b1;
                    SINK_COIN:   result.ready <= ($urandom_range(0, 1) == 1);
                    SINK_SPARSE: result.ready <= ($urandom_range(0, 4) == 0);
                    default:     result.ready <= 1'b0;
                endcase
            end
        end
    end

    // compare each result with the oldest outstanding read
    always @(posedge clk)
    begin : check_results
        read_result_t head;
        if (rst_n && result.valid && result.ready)
        begin
            if (pending_reads.size() == 0)
                report_mismatch("result with no read outstanding", '0, '0,
                                result.inflated_value, '0);
            else
            begin
                head = pending_reads.pop_front();
                if (result.inflated_value !== head.value)
                    report_mismatch("inflated_value", head.row, head.col,
                                    result.inflated_value, head.value);
            end
        end
    end

    // stop a run that no longer moves
    always @(posedge clk)
    begin
        if (!rst_n || wr_en || (item.valid && item.ready) || (result.valid && result.ready))
            idle_cycles = 0;
        else
        begin
            idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    // stimulus sequence
    initial
    begin
        mismatch_count = 0;
        burst_left     = 0;
        idle_cycles    = 0;
        hold_results   = 1'b0;
        rst_n           <= 1'b0;
        wr_en           <= 1'b0;
        wr_index        <= REG_INFLATION;
        wr_data         <= '0;
        item.valid      <= 1'b0;
        item.kind       <= KIND_WRITE;
        item.row        <= '0;
        item.col        <= '0;
        item.cell_value <= '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        test_directed();
        test_map_sweep();
        test_backpressure();
        wait_idle();
        if (mismatch_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// ===== sim.f =====
hdl/oig_pkg.sv
hdl/oig_if.sv
hdl/oig_ram.sv
hdl/oig_alu.sv
hdl/obstacle_inflation_grid.sv
dv/tb_obstacle_inflation_grid.sv
